// ===== rtl/core/plic_lc_pkg.sv =====
// -----------------------------------------------------------------------------
// PLIC line-constant package
// Shared widths, constants, payload types and helpers for the line-constant unit.
// -----------------------------------------------------------------------------
package plic_lc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IW = FRAC_BITS + 1;      // fraction / slope width
   localparam int NW = FRAC_BITS + 4;      // signed normal width
   localparam int AW = FRAC_BITS + 2;      // alpha width
   localparam int MW = FRAC_BITS + 3;      // normal magnitude width
   localparam int RB = FRAC_BITS + 1;      // root bits, quotient bits
   localparam int XW = 2 * RB;             // square root argument width

   localparam logic [IW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [1:0] BAND_LOW  = 2'd0;
   localparam logic [1:0] BAND_MID  = 2'd1;
   localparam logic [1:0] BAND_HIGH = 2'd2;

   typedef logic [8:0][IW-1:0] frac_vec_type;

   typedef struct packed {
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] nz;
      logic [IW-1:0]        c;
   } side_type;

   typedef struct packed {
      logic          valid;
      side_type      side;
      logic [MW-1:0] mn;
      logic [MW-1:0] mx;
      logic          zero;
   } norm_out_type;

   typedef struct packed {
      logic          valid;
      side_type      side;
      logic [IW-1:0] m;
   } div_out_type;

   typedef struct packed {
      logic          valid;
      side_type      side;
      logic [IW-1:0] m;
      logic [AW-1:0] alpha;
   } alpha_out_type;

   function automatic logic [IW-1:0] clamp_frac(input logic [IW-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

endpackage

// ===== rtl/core/plic_lc_norm.sv =====
// -----------------------------------------------------------------------------
// PLIC line-constant normal stages
// Saturates the stencil, forms the Sobel normal, then its magnitude max and min.
// -----------------------------------------------------------------------------
module plic_lc_norm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  plic_lc_pkg::frac_vec_type  in_frac,
   output plic_lc_pkg::norm_out_type  out
);

   logic [plic_lc_pkg::IW-1:0] f [9];
   logic [plic_lc_pkg::MW-1:0] top, bot, lft, rgt;

   logic                  a_valid_ff;
   plic_lc_pkg::side_type a_side_ff, a_side_in;

   logic [plic_lc_pkg::MW-1:0] ax, az;
   plic_lc_pkg::norm_out_type  b_ff, b_in;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         f[k] = plic_lc_pkg::clamp_frac(in_frac[k]);
      end
      top = plic_lc_pkg::MW'(f[0]) + (plic_lc_pkg::MW'(f[1]) << 1) + plic_lc_pkg::MW'(f[2]);
      bot = plic_lc_pkg::MW'(f[6]) + (plic_lc_pkg::MW'(f[7]) << 1) + plic_lc_pkg::MW'(f[8]);
      lft = plic_lc_pkg::MW'(f[0]) + (plic_lc_pkg::MW'(f[3]) << 1) + plic_lc_pkg::MW'(f[6]);
      rgt = plic_lc_pkg::MW'(f[2]) + (plic_lc_pkg::MW'(f[5]) << 1) + plic_lc_pkg::MW'(f[8]);
      a_side_in.nx = $signed({1'b0, top}) - $signed({1'b0, bot});
      a_side_in.nz = $signed({1'b0, lft}) - $signed({1'b0, rgt});
      a_side_in.c  = f[4];
   end

   always_comb begin
      ax = a_side_ff.nx[plic_lc_pkg::NW-1] ? plic_lc_pkg::MW'(-a_side_ff.nx)
                                           : plic_lc_pkg::MW'(a_side_ff.nx);
      az = a_side_ff.nz[plic_lc_pkg::NW-1] ? plic_lc_pkg::MW'(-a_side_ff.nz)
                                           : plic_lc_pkg::MW'(a_side_ff.nz);
      b_in.valid = a_valid_ff;
      b_in.side  = a_side_ff;
      b_in.mx    = (ax > az) ? ax : az;
      b_in.mn    = (ax > az) ? az : ax;
      b_in.zero  = (ax == '0) && (az == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_ff.valid <= b_in.valid;
      end
      if (adv) begin
         a_side_ff <= a_side_in;
         b_ff.side <= b_in.side;
         b_ff.mx   <= b_in.mx;
         b_ff.mn   <= b_in.mn;
         b_ff.zero <= b_in.zero;
      end
   end

   assign out = b_ff;

endmodule

// ===== rtl/core/plic_lc_div.sv =====
// -----------------------------------------------------------------------------
// PLIC line-constant slope divider
// Restoring division m = floor(min * ONE / max), one quotient bit per stage.
// -----------------------------------------------------------------------------
module plic_lc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  plic_lc_pkg::norm_out_type in,
   output plic_lc_pkg::div_out_type  out
);

   localparam int RB = plic_lc_pkg::RB;
   localparam int MW = plic_lc_pkg::MW;
   localparam int IW = plic_lc_pkg::IW;

   logic [RB-1:0]         v_ff;
   logic [MW:0]           r_ff  [RB];
   logic [IW-1:0]         q_ff  [RB];
   logic [MW-1:0]         mx_ff [RB];
   logic [RB-1:0]         z_ff;
   plic_lc_pkg::side_type s_ff  [RB];

   logic [MW:0]           r_in  [RB];
   logic [IW-1:0]         q_in  [RB];

   for (genvar s = 0; s < RB; s++) begin : g_stage
      logic [MW:0]           r_src, r_rem;
      logic [IW-1:0]         q_src;
      logic [MW-1:0]         mx_src;
      logic                  v_src, z_src, ge;
      plic_lc_pkg::side_type s_src;

      if (s == 0) begin : g_first
         assign r_src  = {1'b0, in.mn};
         assign q_src  = '0;
         assign mx_src = in.mx;
         assign v_src  = in.valid;
         assign z_src  = in.zero;
         assign s_src  = in.side;
      end else begin : g_next
         assign r_src  = r_ff[s-1];
         assign q_src  = q_ff[s-1];
         assign mx_src = mx_ff[s-1];
         assign v_src  = v_ff[s-1];
         assign z_src  = z_ff[s-1];
         assign s_src  = s_ff[s-1];
      end

      always_comb begin
         ge       = r_src >= {1'b0, mx_src};
         r_rem    = ge ? (r_src - {1'b0, mx_src}) : r_src;
         r_in[s]  = r_rem << 1;
         q_in[s]  = q_src | (IW'(ge) << (RB - 1 - s));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_src;
         end
         if (adv) begin
            r_ff[s]  <= r_in[s];
            q_ff[s]  <= q_in[s];
            mx_ff[s] <= mx_src;
            z_ff[s]  <= z_src;
            s_ff[s]  <= s_src;
         end
      end
   end

   // both components zero: take m as full
   assign out.valid = v_ff[RB-1];
   assign out.side  = s_ff[RB-1];
   assign out.m     = z_ff[RB-1] ? plic_lc_pkg::ONE : q_ff[RB-1];

endmodule

// ===== rtl/core/plic_lc_alpha.sv =====
// -----------------------------------------------------------------------------
// PLIC line-constant alpha stages
// Band select and root argument product, pipelined square root, final alpha.
// -----------------------------------------------------------------------------
module plic_lc_alpha (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  plic_lc_pkg::div_out_type   in,
   output plic_lc_pkg::alpha_out_type out
);

   localparam int RB = plic_lc_pkg::RB;
   localparam int XW = plic_lc_pkg::XW;
   localparam int IW = plic_lc_pkg::IW;
   localparam int AW = plic_lc_pkg::AW;

   // band and product stage
   logic [IW:0]           c2, hi_lim;
   logic [IW-1:0]         a_op;
   logic [2*IW-1:0]       prod;
   logic [1:0]            band_in, band_ff;
   logic [XW-1:0]         x_in, x_ff;
   logic                  p_valid_ff;
   plic_lc_pkg::side_type p_side_ff;
   logic [IW-1:0]         p_m_ff;

   always_comb begin
      c2     = {in.side.c, 1'b0};
      hi_lim = {plic_lc_pkg::ONE, 1'b0} - {1'b0, in.m};
      if (c2 <= {1'b0, in.m}) begin
         band_in = plic_lc_pkg::BAND_LOW;
      end else if (c2 <= hi_lim) begin
         band_in = plic_lc_pkg::BAND_MID;
      end else begin
         band_in = plic_lc_pkg::BAND_HIGH;
      end
      a_op = (band_in == plic_lc_pkg::BAND_LOW) ? in.side.c
                                                : (plic_lc_pkg::ONE - in.side.c);
      prod = (2*IW)'(a_op) * (2*IW)'(in.m);
      x_in = XW'({prod, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in.valid;
      end
      if (adv) begin
         band_ff   <= band_in;
         x_ff      <= x_in;
         p_side_ff <= in.side;
         p_m_ff    <= in.m;
      end
   end

   // square root, one root bit per stage
   logic [RB-1:0]         v_ff;
   logic [XW:0]           rem_ff  [RB];
   logic [RB-1:0]         root_ff [RB];
   logic [1:0]            bd_ff   [RB];
   logic [IW-1:0]         m_ff    [RB];
   plic_lc_pkg::side_type s_ff    [RB];

   for (genvar s = 0; s < RB; s++) begin : g_root
      logic [XW:0]           rem_src, trial, rem_in;
      logic [RB-1:0]         root_src, root_in;
      logic [1:0]            bd_src;
      logic [IW-1:0]         m_src;
      logic                  v_src;
      plic_lc_pkg::side_type s_src;

      if (s == 0) begin : g_first
         assign rem_src  = {1'b0, x_ff};
         assign root_src = '0;
         assign bd_src   = band_ff;
         assign m_src    = p_m_ff;
         assign v_src    = p_valid_ff;
         assign s_src    = p_side_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign bd_src   = bd_ff[s-1];
         assign m_src    = m_ff[s-1];
         assign v_src    = v_ff[s-1];
         assign s_src    = s_ff[s-1];
      end

      always_comb begin
         trial = ((XW+1)'(root_src) << (RB - s)) + ((XW+1)'(1) << (2 * (RB - 1 - s)));
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (RB'(1) << (RB - 1 - s));
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_src;
         end
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            bd_ff[s]   <= bd_src;
            m_ff[s]    <= m_src;
            s_ff[s]    <= s_src;
         end
      end
   end

   // final alpha
   logic [AW:0]                 mid_sum;
   logic [AW:0]                 high_val;
   plic_lc_pkg::alpha_out_type  o_ff, o_in;

   always_comb begin
      mid_sum  = (AW+1)'({s_ff[RB-1].c, 1'b0}) + (AW+1)'(m_ff[RB-1]);
      high_val = (AW+1)'(m_ff[RB-1]) + (AW+1)'(plic_lc_pkg::ONE)
               - (AW+1)'(root_ff[RB-1]);
      o_in.valid = v_ff[RB-1];
      o_in.side  = s_ff[RB-1];
      o_in.m     = m_ff[RB-1];
      case (bd_ff[RB-1])
         plic_lc_pkg::BAND_LOW:  o_in.alpha = AW'(root_ff[RB-1]);
         plic_lc_pkg::BAND_MID:  o_in.alpha = mid_sum[AW:1];
         default:                o_in.alpha = high_val[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ff.valid <= 1'b0;
      end else if (adv) begin
         o_ff.valid <= o_in.valid;
      end
      if (adv) begin
         o_ff.side  <= o_in.side;
         o_ff.m     <= o_in.m;
         o_ff.alpha <= o_in.alpha;
      end
   end

   assign out = o_ff;

endmodule

// ===== rtl/core/plic_line_constant_2d_unit.sv =====
// -----------------------------------------------------------------------------
// PLIC line-constant unit, 2D
// Youngs/Sobel interface normal, normalized slope and line constant alpha.
// -----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one 3x3 stencil of volume fractions (Q1.16,
//   values above full are saturated). The rsp_ channel returns one
//   transaction per stencil: alpha, the raw normal (x, z) and the slope m.
//   Both channels use valid/stall; a transaction moves when valid is high
//   and stall is low.
//   The pipeline has two normal stages, 17 divider stages (one quotient
//   bit each), one band/product stage, 17 square-root stages (one root bit
//   each) and one output stage. Throughput is one stencil per cycle unless
//   rsp_stall holds a pending result; then the whole pipeline freezes and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Synchronous reset clears all stage valid bits; data registers are not reset.
// -----------------------------------------------------------------------------
module plic_line_constant_2d_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_00,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_01,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_02,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_10,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_11,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_12,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_20,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_21,
   input  logic [plic_lc_pkg::IW-1:0]              req_frac_22,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [plic_lc_pkg::AW-1:0]              rsp_line_alpha,
   output logic signed [plic_lc_pkg::NW-1:0]       rsp_normal_x,
   output logic signed [plic_lc_pkg::NW-1:0]       rsp_normal_z,
   output logic [plic_lc_pkg::IW-1:0]              rsp_min_slope
);

   logic                          adv;
   plic_lc_pkg::frac_vec_type     frac;
   plic_lc_pkg::norm_out_type     norm_out;
   plic_lc_pkg::div_out_type      div_out;
   plic_lc_pkg::alpha_out_type    alpha_out;

   // advance every stage unless a finished result is being held
   assign adv       = !(alpha_out.valid && rsp_stall);
   assign req_stall = !adv;

   assign frac = {req_frac_22, req_frac_21, req_frac_20,
                  req_frac_12, req_frac_11, req_frac_10,
                  req_frac_02, req_frac_01, req_frac_00};

   plic_lc_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_frac  (frac),
      .out      (norm_out)
   );

   plic_lc_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (norm_out),
      .out   (div_out)
   );

   plic_lc_alpha u_alpha (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .in    (div_out),
      .out   (alpha_out)
   );

   assign rsp_valid      = alpha_out.valid;
   assign rsp_line_alpha = alpha_out.alpha;
   assign rsp_normal_x   = alpha_out.side.nx;
   assign rsp_normal_z   = alpha_out.side.nz;
   assign rsp_min_slope  = alpha_out.m;

   a_alpha_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_alpha <= {plic_lc_pkg::ONE, 1'b0})
      else $error("alpha above twice full");

   a_slope_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_slope <= plic_lc_pkg::ONE)
      else $error("slope above full");

   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_normal_x == '0 && rsp_normal_z == '0)
         |-> rsp_min_slope == plic_lc_pkg::ONE)
      else $error("zero normal without full slope");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output held");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// PLIC line-constant unit testbench
// Drives 3x3 fraction stencils with random gaps and checks alpha, normal and
// slope of every result against an in-bench predictor, with random output
// stalls and one long hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAC_BITS = plic_lc_pkg::FRAC_BITS;
   localparam int IW = plic_lc_pkg::IW;
   localparam int NW = plic_lc_pkg::NW;
   localparam int AW = plic_lc_pkg::AW;
   localparam logic [IW-1:0] ONE = plic_lc_pkg::ONE;

   typedef logic [IW-1:0] frac_type;

   typedef struct {
      frac_type f[9];
   } stencil_type;

   typedef struct {
      logic [AW-1:0]        alpha;
      logic signed [NW-1:0] nx;
      logic signed [NW-1:0] nz;
      logic [IW-1:0]        m;
   } line_fit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   frac_type req_f[9] = '{default: '0};
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [AW-1:0] rsp_line_alpha;
   logic signed [NW-1:0] rsp_normal_x;
   logic signed [NW-1:0] rsp_normal_z;
   logic [IW-1:0] rsp_min_slope;

   stencil_type  pending_stencils[$];
   line_fit_type expected_fits[$];
   int  error_count = 0;
   bit  stimulus_done = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   int  accepted = 0;

   plic_line_constant_2d_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_frac_00(req_f[0]), .req_frac_01(req_f[1]), .req_frac_02(req_f[2]),
      .req_frac_10(req_f[3]), .req_frac_11(req_f[4]), .req_frac_12(req_f[5]),
      .req_frac_20(req_f[6]), .req_frac_21(req_f[7]), .req_frac_22(req_f[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_line_alpha(rsp_line_alpha), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_z(rsp_normal_z), .rsp_min_slope(rsp_min_slope)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic line_fit_type fit_line(stencil_type s);
      longint f[9];
      longint nx, nz, ax, az, mx, mn, m, c, a, full;
      line_fit_type r;
      full = longint'(1) << FRAC_BITS;
      for (int k = 0; k < 9; k++) f[k] = (longint'(s.f[k]) > full) ? full : longint'(s.f[k]);
      nx = (f[0] + 2 * f[1] + f[2]) - (f[6] + 2 * f[7] + f[8]);
      nz = (f[0] + 2 * f[3] + f[6]) - (f[2] + 2 * f[5] + f[8]);
      ax = nx < 0 ? -nx : nx;
      az = nz < 0 ? -nz : nz;
      mx = ax > az ? ax : az;
      mn = ax > az ? az : ax;
      m = (mx == 0) ? full : (mn << FRAC_BITS) / mx;
      c = f[4];
      if (2 * c <= m)
         a = longint'(isqrt(2 * c * m));
      else if (2 * c <= 2 * full - m)
         a = (2 * c + m) >> 1;
      else
         a = m + full - longint'(isqrt(2 * (full - c) * m));
      r.alpha = a[AW-1:0];
      r.nx = nx[NW-1:0];
      r.nz = nz[NW-1:0];
      r.m = m[IW-1:0];
      return r;
   endfunction

   function automatic frac_type rand_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONE;
         2: return IW'($urandom_range(ONE + 1, (1 << IW) - 1));  // saturates
         3: return IW'($urandom_range(0, 40));
         4: return ONE - IW'($urandom_range(0, 40));
         default: return IW'($urandom_range(0, ONE));
      endcase
   endfunction

   task automatic add_uniform(frac_type v, frac_type c);
      stencil_type s;
      for (int k = 0; k < 9; k++) s.f[k] = v;
      s.f[4] = c;
      pending_stencils.push_back(s);
   endtask

   // Smooth interface: a half-plane step with a random direction and blur.
   function automatic stencil_type interface_stencil();
      stencil_type s;
      int dx, dz, off;
      longint d;
      dx = int'($urandom_range(0, 40)) - 20;
      dz = int'($urandom_range(0, 40)) - 20;
      off = int'($urandom_range(0, 60)) - 30;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            d = (longint'((i - 1) * dx + (j - 1) * dz + off) * longint'(ONE)) / 40
                + longint'(ONE) / 2;
            if (d < 0) d = 0;
            if (d > longint'(ONE)) d = longint'(ONE);
            s.f[i * 3 + j] = d[IW-1:0];
         end
      return s;
   endfunction

   initial begin
      stencil_type s;
      frac_type zero_f;
      zero_f = '0;
      // both components zero across centre values
      add_uniform(zero_f, zero_f);
      add_uniform(ONE, ONE);
      add_uniform(ONE, zero_f);
      add_uniform(zero_f, ONE / 2);
      add_uniform({IW{1'b1}}, {IW{1'b1}});
      // extreme normals: full top row, empty bottom; full left column; one full corner
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 9; k++) s.f[k] = (k < 3) ? ONE : '0;
         s.f[4] = IW'(c * (ONE / 3));
         pending_stencils.push_back(s);
         for (int k = 0; k < 9; k++) s.f[k] = (k % 3 == 0) ? ONE : '0;
         s.f[4] = IW'(c * (ONE / 3));
         pending_stencils.push_back(s);
         for (int k = 0; k < 9; k++) s.f[k] = (k == 0) ? ONE : '0;
         s.f[4] = ONE - IW'(c);
         pending_stencils.push_back(s);
      end
      // diagonal normal (m = full) through low and high bands
      for (int c = 0; c < 5; c++) begin
         for (int k = 0; k < 9; k++) s.f[k] = (k == 8) ? ONE : '0;
         s.f[4] = IW'(c * (ONE / 4));
         pending_stencils.push_back(s);
      end
      for (int n = 0; n < 1830; n++) begin
         if ($urandom_range(0, 3) != 0) begin
            s = interface_stencil();
         end else begin
            for (int k = 0; k < 9; k++) s.f[k] = rand_frac();
         end
         pending_stencils.push_back(s);
      end
      stimulus_done = 1;
   end

   task automatic s_drive();
      stencil_type s;
      s = pending_stencils.pop_front();
      for (int k = 0; k < 9; k++) req_f[k] <= s.f[k];
      req_valid <= 1'b1;
      expected_fits.push_back(fit_line(s));
      send_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) accepted <= accepted + 1;
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_stencils.size() > 0) begin
            s_drive();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random gaps, one long hold-off mid-run
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (accepted == 400 && hold_left == 0) begin
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else if (hold_left == 1) begin
         hold_left <= -1;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         recv_gap <= ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0;
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      line_fit_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fits.size() == 0) begin
            $display("%0t: unexpected result alpha=%0d", $time, rsp_line_alpha);
            error_count <= error_count + 1;
         end else begin
            e = expected_fits.pop_front();
            if (e.alpha !== rsp_line_alpha || e.nx !== rsp_normal_x ||
                e.nz !== rsp_normal_z || e.m !== rsp_min_slope) begin
               $display("%0t: mismatch expected a=%0d nx=%0d nz=%0d m=%0d",
                        $time, e.alpha, e.nx, e.nz, e.m);
               $display("%0t:          got a=%0d nx=%0d nz=%0d m=%0d",
                        $time, rsp_line_alpha, rsp_normal_x, rsp_normal_z,
                        rsp_min_slope);
               error_count <= error_count + 1;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_stencils.size() == 0 && !req_valid);
      wait (expected_fits.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_fits.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end
endmodule
